>>> hdl/mandelbox_distance_estimator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Mandelbox distance estimator
// Clock clk and reset arst_n are taken from the module that uses them.
// ----------------------------------------------------------------------------
`ifndef MANDELBOX_DISTANCE_ESTIMATOR_ASSERT_SVH
`define MANDELBOX_DISTANCE_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define MDE_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("mde assertion failed");

// next-cycle implication
`define MDE_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("mde assertion failed");

`endif

>>> hdl/mde_pkg.sv
// ----------------------------------------------------------------------------
// mde_pkg
// Shared types and saturating helpers for the Mandelbox distance estimator.
// ----------------------------------------------------------------------------
package mde_pkg;

	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] ITER_RESET = 4'd8;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_FOLD,
		DP_SQ_START,
		DP_SQ_END,
		DP_FAC_SEL,
		DP_FAC_END,
		DP_SC1_START,
		DP_SC1_END,
		DP_SC2_START,
		DP_SC2_END,
		DP_LEN_END,
		DP_SQRT_START,
		DP_SQRT_END,
		DP_DDIV_START,
		DP_DDIV_END,
		DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] lane;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic sqrt_done;
		logic fac_need_div;
	} dp_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_FOLD,
		ST_SQ,
		ST_SQ_WAIT,
		ST_FAC,
		ST_FAC_WAIT,
		ST_SC1,
		ST_SC1_WAIT,
		ST_SC2,
		ST_SC2_WAIT,
		ST_LEN,
		ST_LEN_WAIT,
		ST_SQRT,
		ST_SQRT_WAIT,
		ST_DDIV,
		ST_DDIV_WAIT,
		ST_OUTPUT
	} state_t;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] mag(input logic signed [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic signed [63:0] from_mag(input logic neg, input logic [127:0] m);
		if (neg)
			return (|m[127:63]) ? S64_MIN : (64'd0 - m[63:0]);
		return (|m[127:63]) ? S64_MAX : m[63:0];
	endfunction

endpackage

>>> hdl/mandelbox_distance_estimator.sv
// ----------------------------------------------------------------------------
// mandelbox_distance_estimator
// Fixed-point Mandelbox distance estimate for one point per command.
// ----------------------------------------------------------------------------
// Raise start with pos_x/pos_y/pos_z while busy is low; the point is taken on
// that edge. Some time later done is high for exactly one cycle with distance
// valid; the receiver cannot stall, so capture it then. One point is worked on
// at a time. The cost is set by the shared 64x64 multiplier (four 32x32
// partials), the bit-serial divider and square root; the time from the
// accepting edge to the edge that transfers distance grows with the iteration
// count N (capped at MAX_ITERATIONS) and with every iteration whose sphere
// fold needs a reciprocal (0.25 < r2 < 1).
// iteration_count may be written with cfg_we/cfg_data only while busy is low.
module mandelbox_distance_estimator #(
	parameter int MAX_ITERATIONS = 12,
	parameter int FRAC_BITS      = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      cfg_we,
	input  logic [mde_pkg::CFG_W-1:0] cfg_data,
	input  logic signed [23:0]        pos_x,
	input  logic signed [23:0]        pos_y,
	input  logic signed [23:0]        pos_z,
	output logic                      done,
	output logic signed [31:0]        distance
);
	import mde_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	mde_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .sts(sts), .cmd(cmd)
	);

	mde_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .distance(distance)
	);

endmodule

>>> hdl/mde_datapath.sv
// ----------------------------------------------------------------------------
// mde_datapath
// Lane registers, shared sequential multiplier, divider and square root unit.
// ----------------------------------------------------------------------------
module mde_datapath #(
	parameter int FRAC_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mde_pkg::dp_cmd_t      cmd,
	output mde_pkg::dp_sts_t      sts,
	input  logic signed [23:0]    pos_x,
	input  logic signed [23:0]    pos_y,
	input  logic signed [23:0]    pos_z,
	output logic signed [31:0]    distance
);
	import mde_pkg::*;

	localparam logic signed [63:0] ONE     = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] QUARTER = 64'sd1 <<< (FRAC_BITS - 2);
	localparam logic [63:0] MIX  = ((64'd112 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam logic [63:0] BAIL = ((64'd18 << FRAC_BITS) + 64'd5) / 64'd10;
	localparam logic [63:0] POW9 = 64'd10578455953408;
	localparam logic [63:0] TINY = ((64'd1 << FRAC_BITS) * 64'd1000000000 + POW9 / 64'd2)
		/ POW9;
	localparam int POS_SH    = (FRAC_BITS >= 20) ? FRAC_BITS - 20 : 0;
	localparam int POS_DSH   = (FRAC_BITS < 20) ? 20 - FRAC_BITS : 0;
	localparam logic signed [63:0] POS_DIV = 64'sd1 <<< POS_DSH;
	localparam int OUT_SH    = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
	localparam int OUT_ML    = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
	localparam logic signed [63:0] OUT_DIV = 64'sd1 <<< OUT_SH;
	localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
	localparam logic signed [63:0] SAT_HI  = I32_MAX / (64'sd1 <<< OUT_ML);
	localparam logic signed [63:0] SAT_LO  = I32_MIN / (64'sd1 <<< OUT_ML);
	localparam logic [127:0] FAC_NUM = 128'd1 << (2 * FRAC_BITS - 2);

	logic signed [63:0] x_q, y_q, z_q, w_q, x0_q, y0_q, z0_q;
	logic signed [63:0] rsq_q, fac_q, t_q, len_q, dist_q;
	logic [127:0] sum_q;
	logic         num_neg_q;
	logic signed [31:0] distance_q;

	// multiplier
	logic [63:0]  ma_q, mb_q;
	logic         mneg_q, mrun_q, mdone_q;
	logic [1:0]   mcnt_q;
	logic [127:0] prod_q;
	logic [63:0]  pp;
	logic [6:0]   pp_sh;
	logic signed [63:0] fres;

	// divider
	logic [127:0] dvd_q, quo_q;
	logic [63:0]  den_q, drem_q;
	logic [6:0]   dcnt_q;
	logic         drun_q, ddone_q;
	logic [64:0]  drem_n;
	logic         dge;

	// square root
	logic [127:0] rad_q;
	logic [66:0]  srem_q, srem_n, strial;
	logic [63:0]  root_q;
	logic [5:0]   scnt_q;
	logic         srun_q, sdone_q;

	logic signed [63:0] lane_v, lane_s, ma_v, mb_v, px, py, pz, num_v, w_fix;
	logic signed [31:0] out_conv;
	logic signed [63:0] out_div;

	function automatic logic signed [63:0] scale_pos(input logic signed [23:0] p);
		logic signed [63:0] e;
		e = 64'(p);
		if (FRAC_BITS >= 20)
			return e <<< POS_SH;
		return e / POS_DIV;
	endfunction

	always_comb begin
		case (cmd.lane)
			2'd0:    begin lane_v = x_q; lane_s = x0_q; end
			2'd1:    begin lane_v = y_q; lane_s = y0_q; end
			2'd2:    begin lane_v = z_q; lane_s = z0_q; end
			default: begin lane_v = w_q; lane_s = ONE;  end
		endcase
		case (cmd.op)
			DP_SC1_START: begin ma_v = lane_v; mb_v = fac_q; end
			DP_SC2_START: begin ma_v = t_q;    mb_v = MIX;   end
			default:      begin ma_v = lane_v; mb_v = lane_v; end
		endcase
	end

	assign px = scale_pos(pos_x);
	assign py = scale_pos(pos_y);
	assign pz = sadd(scale_pos(pos_z), 64'sd3 <<< FRAC_BITS);

	assign pp    = 64'(ma_q[mcnt_q[0]*32 +: 32]) * 64'(mb_q[mcnt_q[1]*32 +: 32]);
	assign pp_sh = (7'(mcnt_q[0]) + 7'(mcnt_q[1])) << 5;
	assign fres  = from_mag(mneg_q, prod_q >> FRAC_BITS);

	assign drem_n = {drem_q, dvd_q[127]};
	assign dge    = drem_n >= {1'b0, den_q};

	assign srem_n = {srem_q[64:0], rad_q[127:126]};
	assign strial = {1'b0, root_q, 2'b01};

	assign num_v = ssub(len_q, BAIL);
	assign w_fix = (w_q <= 64'sd0) ? 64'sd1 : w_q;

	always_comb begin
		out_div = dist_q / OUT_DIV;
		if (FRAC_BITS >= 24) begin
			if (out_div > I32_MAX)      out_conv = 32'sh7FFF_FFFF;
			else if (out_div < I32_MIN) out_conv = 32'sh8000_0000;
			else                        out_conv = out_div[31:0];
		end else begin
			if (dist_q > SAT_HI)        out_conv = 32'sh7FFF_FFFF;
			else if (dist_q < SAT_LO)   out_conv = 32'sh8000_0000;
			else                        out_conv = 32'(dist_q <<< OUT_ML);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q  <= 1'b0;
			mdone_q <= 1'b0;
			drun_q  <= 1'b0;
			ddone_q <= 1'b0;
			srun_q  <= 1'b0;
			sdone_q <= 1'b0;
		end else begin
			mdone_q <= mrun_q && (mcnt_q == 2'd3);
			ddone_q <= drun_q && (dcnt_q == 7'd127);
			sdone_q <= srun_q && (scnt_q == 6'd63);
			if (mrun_q && mcnt_q == 2'd3) mrun_q <= 1'b0;
			if (drun_q && dcnt_q == 7'd127) drun_q <= 1'b0;
			if (srun_q && scnt_q == 6'd63) srun_q <= 1'b0;
			if (cmd.op == DP_SQ_START || cmd.op == DP_SC1_START || cmd.op == DP_SC2_START)
				mrun_q <= 1'b1;
			if ((cmd.op == DP_FAC_SEL && sts.fac_need_div) || cmd.op == DP_DDIV_START)
				drun_q <= 1'b1;
			if (cmd.op == DP_SQRT_START)
				srun_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mrun_q) begin
			prod_q <= prod_q + ({64'd0, pp} << pp_sh);
			mcnt_q <= mcnt_q + 2'd1;
		end
		if (drun_q) begin
			drem_q <= dge ? 64'(drem_n - {1'b0, den_q}) : drem_n[63:0];
			quo_q  <= {quo_q[126:0], dge};
			dvd_q  <= dvd_q << 1;
			dcnt_q <= dcnt_q + 7'd1;
		end
		if (srun_q) begin
			if (srem_n >= strial) begin
				srem_q <= srem_n - strial;
				root_q <= {root_q[62:0], 1'b1};
			end else begin
				srem_q <= srem_n;
				root_q <= {root_q[62:0], 1'b0};
			end
			rad_q  <= rad_q << 2;
			scnt_q <= scnt_q + 6'd1;
		end
		case (cmd.op)
			DP_LOAD: begin
				x_q <= px; y_q <= py; z_q <= pz;
				x0_q <= px; y0_q <= py; z0_q <= pz;
				w_q <= ONE;
				sum_q <= '0;
			end
			DP_FOLD: begin
				x_q <= ssub((x_q > ONE ? ONE : (x_q < -ONE ? -ONE : x_q)) <<< 1, x_q);
				y_q <= ssub((y_q > ONE ? ONE : (y_q < -ONE ? -ONE : y_q)) <<< 1, y_q);
				z_q <= ssub((z_q > ONE ? ONE : (z_q < -ONE ? -ONE : z_q)) <<< 1, z_q);
				rsq_q <= '0;
			end
			DP_SQ_START, DP_SC1_START, DP_SC2_START: begin
				ma_q   <= mag(ma_v);
				mb_q   <= mag(mb_v);
				mneg_q <= ma_v[63] ^ mb_v[63];
				prod_q <= '0;
				mcnt_q <= '0;
			end
			DP_SQ_END:  rsq_q <= sadd(rsq_q, fres);
			DP_LEN_END: sum_q <= sum_q + prod_q;
			DP_FAC_SEL: begin
				fac_q  <= (rsq_q <= QUARTER) ? ONE : QUARTER;
				dvd_q  <= FAC_NUM;
				den_q  <= rsq_q;
				drem_q <= '0;
				quo_q  <= '0;
				dcnt_q <= '0;
			end
			DP_FAC_END: fac_q <= quo_q[63:0];
			DP_SC1_END: t_q <= fres;
			DP_SC2_END: begin
				case (cmd.lane)
					2'd0:    x_q <= sadd(fres, lane_s);
					2'd1:    y_q <= sadd(fres, lane_s);
					2'd2:    z_q <= sadd(fres, lane_s);
					default: w_q <= sadd(fres, lane_s);
				endcase
			end
			DP_SQRT_START: begin
				rad_q  <= sum_q;
				srem_q <= '0;
				root_q <= '0;
				scnt_q <= '0;
			end
			DP_SQRT_END: len_q <= root_q[63] ? S64_MAX : root_q;
			DP_DDIV_START: begin
				num_neg_q <= num_v[63];
				dvd_q     <= {64'd0, mag(num_v)} << FRAC_BITS;
				den_q     <= w_fix;
				drem_q    <= '0;
				quo_q     <= '0;
				dcnt_q    <= '0;
			end
			DP_DDIV_END: dist_q <= ssub(from_mag(num_neg_q, quo_q), TINY);
			DP_OUT:      distance_q <= out_conv;
			default: ;
		endcase
	end

	assign sts.mul_done     = mdone_q;
	assign sts.div_done     = ddone_q;
	assign sts.sqrt_done    = sdone_q;
	assign sts.fac_need_div = (rsq_q > QUARTER) && (rsq_q < ONE);
	assign distance         = distance_q;

endmodule

>>> hdl/mde_ctrl.sv
// ----------------------------------------------------------------------------
// mde_ctrl
// Sequencer: iteration and lane counters, configuration register, handshake.
// ----------------------------------------------------------------------------
`include "mandelbox_distance_estimator_assert.svh"

module mde_ctrl #(
	parameter int MAX_ITERATIONS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output logic                        done,
	input  logic                        cfg_we,
	input  logic [mde_pkg::CFG_W-1:0]   cfg_data,
	input  mde_pkg::dp_sts_t            sts,
	output mde_pkg::dp_cmd_t            cmd
);
	import mde_pkg::*;

	localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

	state_t state_q, state_d;
	logic [CFG_W-1:0]  iter_cfg_q;
	logic [ITER_W-1:0] it_q, it_d, n_q, n_d;
	logic [1:0]        lane_q, lane_d;
	logic              done_q, done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iter_cfg_q <= ITER_RESET;
			it_q       <= '0;
			n_q        <= '0;
			lane_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			it_q    <= it_d;
			n_q     <= n_d;
			lane_q  <= lane_d;
			done_q  <= done_d;
			if (cfg_we) iter_cfg_q <= cfg_data;
		end
	end

	always_comb begin
		state_d  = state_q;
		it_d     = it_q;
		n_d      = n_q;
		lane_d   = lane_q;
		done_d   = 1'b0;
		cmd.op   = DP_NOP;
		cmd.lane = lane_q;
		case (state_q)
			ST_IDLE: if (start) begin
				cmd.op  = DP_LOAD;
				it_d    = '0;
				n_d     = (32'(iter_cfg_q) > MAX_ITERATIONS) ? ITER_W'(MAX_ITERATIONS)
					: ITER_W'(iter_cfg_q);
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				lane_d  = '0;
				state_d = (it_q == n_q) ? ST_LEN : ST_FOLD;
			end
			ST_FOLD: begin
				cmd.op  = DP_FOLD;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.op  = DP_SQ_START;
				state_d = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: if (sts.mul_done) begin
				cmd.op = DP_SQ_END;
				if (lane_q == 2'd2) begin
					state_d = ST_FAC;
				end else begin
					lane_d  = lane_q + 2'd1;
					state_d = ST_SQ;
				end
			end
			ST_FAC: begin
				cmd.op  = DP_FAC_SEL;
				lane_d  = '0;
				state_d = sts.fac_need_div ? ST_FAC_WAIT : ST_SC1;
			end
			ST_FAC_WAIT: if (sts.div_done) begin
				cmd.op  = DP_FAC_END;
				state_d = ST_SC1;
			end
			ST_SC1: begin
				cmd.op  = DP_SC1_START;
				state_d = ST_SC1_WAIT;
			end
			ST_SC1_WAIT: if (sts.mul_done) begin
				cmd.op  = DP_SC1_END;
				state_d = ST_SC2;
			end
			ST_SC2: begin
				cmd.op  = DP_SC2_START;
				state_d = ST_SC2_WAIT;
			end
			ST_SC2_WAIT: if (sts.mul_done) begin
				cmd.op = DP_SC2_END;
				if (lane_q == 2'd3) begin
					it_d    = it_q + 1'b1;
					state_d = ST_CHECK;
				end else begin
					lane_d  = lane_q + 2'd1;
					state_d = ST_SC1;
				end
			end
			ST_LEN: begin
				cmd.op  = DP_SQ_START;
				state_d = ST_LEN_WAIT;
			end
			ST_LEN_WAIT: if (sts.mul_done) begin
				cmd.op = DP_LEN_END;
				if (lane_q == 2'd2) begin
					state_d = ST_SQRT;
				end else begin
					lane_d  = lane_q + 2'd1;
					state_d = ST_LEN;
				end
			end
			ST_SQRT: begin
				cmd.op  = DP_SQRT_START;
				state_d = ST_SQRT_WAIT;
			end
			ST_SQRT_WAIT: if (sts.sqrt_done) begin
				cmd.op  = DP_SQRT_END;
				state_d = ST_DDIV;
			end
			ST_DDIV: begin
				cmd.op  = DP_DDIV_START;
				state_d = ST_DDIV_WAIT;
			end
			ST_DDIV_WAIT: if (sts.div_done) begin
				cmd.op  = DP_DDIV_END;
				state_d = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				cmd.op  = DP_OUT;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	`MDE_ASSERT_IMP(a_done_idle, done, !busy)
	`MDE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`MDE_ASSERT_NXT(a_done_pulse, done, !done)
	`MDE_ASSERT_IMP(a_fold_in_range, state_q == ST_FOLD, it_q < n_q)

endmodule
